[hdl/mwtd_pkg.sv]
// mwtd_pkg: shared types, codes and defaults for the motion/weight take detector.
// No dependencies.
package mwtd_pkg;

    localparam logic [31:0] BOOT_GUARD_MS_DEF       = 32'd5000;
    localparam logic [31:0] IDLE_COOLDOWN_MS_DEF    = 32'd5000;
    localparam logic [31:0] CROSSTALK_WINDOW_MS_DEF = 32'd500;

    // event kinds
    localparam logic [1:0] KIND_TAKE_OK     = 2'd0;
    localparam logic [1:0] KIND_TAKE_RETURN = 2'd1;
    localparam logic [1:0] KIND_OPEN_NOTAKE = 2'd2;
    localparam logic [1:0] KIND_NO_MOTION   = 2'd3;

    // per-compartment phases
    localparam logic [1:0] PH_IDLE        = 2'd0;
    localparam logic [1:0] PH_WAIT_TAKE   = 2'd1;
    localparam logic [1:0] PH_WAIT_RETURN = 2'd2;

    // register indexes
    localparam logic [2:0] REG_WEIGHT_DELTA = 3'd0;
    localparam logic [2:0] REG_DOSE         = 3'd1;
    localparam logic [2:0] REG_RETURN       = 3'd2;
    localparam logic [2:0] REG_STABLE_CNT   = 3'd3;
    localparam logic [2:0] REG_WAIT_WIN     = 3'd4;
    localparam logic [2:0] REG_RETURN_WIN   = 3'd5;
    localparam logic [2:0] REG_NO_MOTION    = 3'd6;
    localparam logic [2:0] REG_SECOND_EN    = 3'd7;

    // 2^25/3 rounded up; exact quotient for magnitudes below 2^25
    localparam logic [23:0] RECIP3 = 24'd11184811;

    typedef struct packed {
        logic [22:0] weight_delta_threshold;
        logic [22:0] dose_threshold;
        logic [22:0] return_threshold;
        logic [7:0]  return_stable_count;
        logic [31:0] wait_window_ms;
        logic [31:0] return_window_ms;
        logic [31:0] no_motion_anomaly_ms;
        logic        second_scale_enable;
    } mwtd_cfg_t;

    typedef struct packed {
        logic               comp;
        logic               motion;
        logic signed [23:0] weight;
        logic [31:0]        now_ms;
        logic               boot;
    } mwtd_item_t;

    typedef struct packed {
        logic       comp;
        logic [1:0] kind;
    } mwtd_result_t;

    function automatic logic [25:0] abs26(input logic signed [25:0] v);
        abs26 = v[25] ? 26'(-v) : 26'(v);
    endfunction

endpackage

[hdl/motion_weight_take_detector_top.sv]
// motion_weight_take_detector_top: configuration registers and the three parts.
// Depends on mwtd_pkg, mwtd_front, mwtd_back, mwtd_outq.
//
// Usage:
//  Samples enter through a queue port: an item is taken when push is high
//  and full is low. Each carries compartment, motion, weight and now_ms.
//  Samples for compartment 1 are dropped at the door while
//  second_scale_enable is 0.
//  Events leave through a queue port: while empty is low the oldest event
//  is on event_compartment/event_kind/medicine_taken; pop takes it.
//  Configuration: cfg_valid/cfg_ready with cfg_index (register 0..7) and
//  cfg_data; cfg_ready is always high, write only while the block is idle.
//  Work: the back end takes one sample at a time through pop, history sum,
//  divide-by-three multiply and update, and pops the next sample only
//  after the update; the event is pushed to the output queue at update.
//  A two-entry input queue lets new samples in while one is at work.
//  When the receiver stalls, up to two events wait in the output queue;
//  beyond that the back end holds its update, then the input queue fills
//  and full rises. Nothing is dropped.
//  Reset clears all compartment state, both queues, and loads the
//  register defaults.
module motion_weight_take_detector_top #(
    parameter logic [31:0] BOOT_GUARD_MS       = mwtd_pkg::BOOT_GUARD_MS_DEF,
    parameter logic [31:0] IDLE_COOLDOWN_MS    = mwtd_pkg::IDLE_COOLDOWN_MS_DEF,
    parameter logic [31:0] CROSSTALK_WINDOW_MS = mwtd_pkg::CROSSTALK_WINDOW_MS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               compartment,
    input  logic               motion,
    input  logic signed [23:0] weight,
    input  logic [31:0]        now_ms,
    output logic               empty,
    input  logic               pop,
    output logic               event_compartment,
    output logic [1:0]         event_kind,
    output logic               medicine_taken,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    mwtd_pkg::mwtd_cfg_t    cfg_reg;
    mwtd_pkg::mwtd_item_t   item;
    mwtd_pkg::mwtd_result_t res;
    logic item_valid, item_pop, res_push, res_full;

    assign cfg_ready = 1'b1;

    // register file: each write masks data to the register width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.weight_delta_threshold <= 23'd20000;
            cfg_reg.dose_threshold         <= 23'd2000;
            cfg_reg.return_threshold       <= 23'd10000;
            cfg_reg.return_stable_count    <= 8'd3;
            cfg_reg.wait_window_ms         <= 32'd10000;
            cfg_reg.return_window_ms       <= 32'd30000;
            cfg_reg.no_motion_anomaly_ms   <= 32'd5000;
            cfg_reg.second_scale_enable    <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mwtd_pkg::REG_WEIGHT_DELTA: cfg_reg.weight_delta_threshold <= cfg_data[22:0];
                mwtd_pkg::REG_DOSE:         cfg_reg.dose_threshold         <= cfg_data[22:0];
                mwtd_pkg::REG_RETURN:       cfg_reg.return_threshold       <= cfg_data[22:0];
                mwtd_pkg::REG_STABLE_CNT:   cfg_reg.return_stable_count    <= cfg_data[7:0];
                mwtd_pkg::REG_WAIT_WIN:     cfg_reg.wait_window_ms         <= cfg_data;
                mwtd_pkg::REG_RETURN_WIN:   cfg_reg.return_window_ms       <= cfg_data;
                mwtd_pkg::REG_NO_MOTION:    cfg_reg.no_motion_anomaly_ms   <= cfg_data;
                mwtd_pkg::REG_SECOND_EN:    cfg_reg.second_scale_enable    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    mwtd_front #(.BOOT_GUARD_MS(BOOT_GUARD_MS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .compartment(compartment), .motion(motion), .weight(weight), .now_ms(now_ms),
        .second_scale_enable(cfg_reg.second_scale_enable),
        .item_valid(item_valid), .item(item), .item_pop(item_pop)
    );

    mwtd_back #(
        .IDLE_COOLDOWN_MS(IDLE_COOLDOWN_MS),
        .CROSSTALK_WINDOW_MS(CROSSTALK_WINDOW_MS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .item_valid(item_valid), .item(item), .item_pop(item_pop),
        .res_push(res_push), .res(res), .res_full(res_full)
    );

    mwtd_outq u_outq (
        .clk(clk), .rst_n(rst_n), .res_push(res_push), .res(res), .res_full(res_full),
        .empty(empty), .pop(pop), .event_compartment(event_compartment),
        .event_kind(event_kind), .medicine_taken(medicine_taken)
    );
endmodule

[hdl/mwtd_front.sv]
// mwtd_front: input queue; drops samples of a disabled second scale, tags boot-guard samples.
// Depends on mwtd_pkg.
module mwtd_front #(
    parameter logic [31:0] BOOT_GUARD_MS = mwtd_pkg::BOOT_GUARD_MS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 compartment,
    input  logic                 motion,
    input  logic signed [23:0]   weight,
    input  logic [31:0]          now_ms,
    input  logic                 second_scale_enable,
    output logic                 item_valid,
    output mwtd_pkg::mwtd_item_t item,
    input  logic                 item_pop
);
    mwtd_pkg::mwtd_item_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wptr_reg, rptr_reg;
    logic       wr, rd;

    assign full       = cnt_reg == 2'd2;
    assign item_valid = cnt_reg != 2'd0;
    assign item       = q_reg[rptr_reg];
    assign rd         = item_pop && item_valid;
    assign wr         = push && !full && !(compartment && !second_scale_enable);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr) wptr_reg <= !wptr_reg;
            if (rd) rptr_reg <= !rptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wptr_reg] <= '{comp: compartment, motion: motion, weight: weight,
                                 now_ms: now_ms, boot: now_ms < BOOT_GUARD_MS};
        end
    end
endmodule

[hdl/mwtd_back.sv]
// mwtd_back: per-compartment state and the take/return machine, one sample at a time.
// Depends on mwtd_pkg.
module mwtd_back #(
    parameter logic [31:0] IDLE_COOLDOWN_MS    = mwtd_pkg::IDLE_COOLDOWN_MS_DEF,
    parameter logic [31:0] CROSSTALK_WINDOW_MS = mwtd_pkg::CROSSTALK_WINDOW_MS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mwtd_pkg::mwtd_cfg_t    cfg,
    input  logic                   item_valid,
    input  mwtd_pkg::mwtd_item_t   item,
    output logic                   item_pop,
    output logic                   res_push,
    output mwtd_pkg::mwtd_result_t res,
    input  logic                   res_full
);
    typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_MUL, ST_EXEC} st_t;
    st_t state_reg;

    logic [1:0]         phase_reg [2];
    logic [31:0]        edge_reg  [2];
    logic               mwh_reg   [2];
    logic signed [23:0] ref_reg   [2];
    logic signed [23:0] tbase_reg [2];
    logic [31:0]        ttime_reg [2];
    logic [7:0]         hits_reg  [2];
    logic signed [23:0] hist_reg  [2][3];
    logic [1:0]         hcnt_reg  [2];
    logic [31:0]        lmt_reg   [2];
    logic signed [23:0] prev_reg  [2];
    logic               seen_reg  [2];
    logic [31:0]        let_reg   [2];

    mwtd_pkg::mwtd_item_t it_reg;
    logic               c;
    logic [24:0]        mag_reg;
    logic               neg_reg;
    logic signed [23:0] simple_reg;
    logic [48:0]        prod_reg;

    // SUM stage
    logic signed [25:0] sum3;
    logic signed [24:0] sum2;
    logic signed [24:0] half2;

    assign c    = it_reg.comp;
    assign sum3 = 26'(hist_reg[c][0]) + 26'(hist_reg[c][1]) + 26'(hist_reg[c][2]);
    assign sum2 = 25'(hist_reg[c][0]) + 25'(hist_reg[c][1]);
    assign half2 = (sum2 + 25'(sum2[24])) >>> 1;   // toward zero

    // EXEC combinational
    logic signed [24:0] q3;
    logic signed [23:0] base;
    logic               boot, arm, cancel, hit, concl, taken, quiet;
    logic [1:0]         ph, ph_new;
    logic [31:0]        edge_n, lmt_n, sdiff;
    logic signed [23:0] ref_n, prev0;
    logic [7:0]         hits_n;
    logic [25:0]        thr_wd;
    logic               emit;
    logic [1:0]         kind;
    logic               set_take, set_let;

    always_comb
    begin
        q3     = 25'(prod_reg[48:25]);
        base   = (hcnt_reg[c] == 2'd3) ? 24'(neg_reg ? -q3 : q3) : simple_reg;
        boot   = it_reg.boot;
        prev0  = seen_reg[c] ? prev_reg[c] : it_reg.weight;
        lmt_n  = it_reg.motion ? it_reg.now_ms : lmt_reg[c];
        arm    = !boot && phase_reg[c] == mwtd_pkg::PH_IDLE && it_reg.motion && !mwh_reg[c];
        ph     = arm ? mwtd_pkg::PH_WAIT_TAKE : phase_reg[c];
        edge_n = arm ? it_reg.now_ms : edge_reg[c];
        ref_n  = arm ? base : ref_reg[c];
        thr_wd = {3'b000, cfg.weight_delta_threshold};
        sdiff  = edge_n - edge_reg[!c];
        cancel = cfg.second_scale_enable && phase_reg[!c] == mwtd_pkg::PH_WAIT_RETURN &&
                 (($signed(sdiff) < $signed(CROSSTALK_WINDOW_MS) &&
                   $signed(sdiff) > -$signed(CROSSTALK_WINDOW_MS)) ||
                  (edge_reg[!c] != 32'd0 && edge_n > edge_reg[!c]));
        hit    = mwtd_pkg::abs26(26'(it_reg.weight) - 26'(tbase_reg[c])) <
                 {3'b000, cfg.return_threshold};
        hits_n = hit ? ((hits_reg[c] == 8'hFF) ? 8'hFF : hits_reg[c] + 8'd1) : 8'd0;
        concl  = hit && hits_n >= cfg.return_stable_count;
        taken  = mwtd_pkg::abs26(26'(tbase_reg[c]) - 26'(it_reg.weight)) >
                 {3'b000, cfg.dose_threshold};
        quiet  = !(it_reg.now_ms - let_reg[c] < IDLE_COOLDOWN_MS ||
                   it_reg.now_ms - lmt_n < cfg.no_motion_anomaly_ms);
        ph_new   = ph;
        emit     = 1'b0;
        kind     = mwtd_pkg::KIND_TAKE_OK;
        set_take = 1'b0;
        set_let  = 1'b0;
        if (!boot)
        begin
            if (ph == mwtd_pkg::PH_WAIT_TAKE)
            begin
                if (cancel)
                begin
                    ph_new = mwtd_pkg::PH_IDLE;
                end
                else if ($signed(26'(ref_n) - 26'(it_reg.weight)) > $signed(thr_wd))
                begin
                    ph_new   = mwtd_pkg::PH_WAIT_RETURN;
                    set_take = 1'b1;
                end
                else if (it_reg.now_ms - edge_n > cfg.wait_window_ms)
                begin
                    ph_new = mwtd_pkg::PH_IDLE;
                    emit   = 1'b1;
                    kind   = mwtd_pkg::KIND_OPEN_NOTAKE;
                end
            end
            else if (ph == mwtd_pkg::PH_WAIT_RETURN)
            begin
                if (concl)
                begin
                    ph_new = mwtd_pkg::PH_IDLE;
                    emit   = 1'b1;
                    kind   = taken ? mwtd_pkg::KIND_TAKE_OK : mwtd_pkg::KIND_TAKE_RETURN;
                end
                else if (it_reg.now_ms - ttime_reg[c] > cfg.return_window_ms)
                begin
                    ph_new = mwtd_pkg::PH_IDLE;
                    emit   = 1'b1;
                    kind   = mwtd_pkg::KIND_TAKE_OK;
                end
            end
            else if (quiet &&
                     mwtd_pkg::abs26(26'(it_reg.weight) - 26'(prev0)) > thr_wd)
            begin
                emit = 1'b1;
                kind = mwtd_pkg::KIND_NO_MOTION;
            end
        end
        set_let = emit;
    end

    logic adv;
    assign adv      = state_reg == ST_EXEC && !(emit && res_full);
    assign item_pop = state_reg == ST_IDLE && item_valid;
    assign res_push = adv && emit;
    assign res      = '{comp: c, kind: kind};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < 2; i++)
            begin
                phase_reg[i] <= mwtd_pkg::PH_IDLE;
                edge_reg[i]  <= '0;
                mwh_reg[i]   <= 1'b0;
                ref_reg[i]   <= '0;
                tbase_reg[i] <= '0;
                ttime_reg[i] <= '0;
                hits_reg[i]  <= '0;
                hcnt_reg[i]  <= '0;
                lmt_reg[i]   <= '0;
                prev_reg[i]  <= '0;
                seen_reg[i]  <= 1'b0;
                let_reg[i]   <= '0;
                for (int j = 0; j < 3; j++)
                begin
                    hist_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid) state_reg <= ST_SUM;
                end
                ST_SUM:  state_reg <= ST_MUL;
                ST_MUL:  state_reg <= ST_EXEC;
                ST_EXEC:
                begin
                    if (adv)
                    begin
                        state_reg      <= ST_IDLE;
                        hist_reg[c][2] <= hist_reg[c][1];
                        hist_reg[c][1] <= hist_reg[c][0];
                        hist_reg[c][0] <= it_reg.weight;
                        if (hcnt_reg[c] != 2'd3) hcnt_reg[c] <= hcnt_reg[c] + 2'd1;
                        prev_reg[c] <= it_reg.weight;
                        seen_reg[c] <= 1'b1;
                        lmt_reg[c]  <= lmt_n;
                        mwh_reg[c]  <= it_reg.motion;
                        if (!boot)
                        begin
                            phase_reg[c] <= ph_new;
                            edge_reg[c]  <= edge_n;
                            ref_reg[c]   <= ref_n;
                            if (ph == mwtd_pkg::PH_WAIT_RETURN) hits_reg[c] <= hits_n;
                            if (set_take)
                            begin
                                tbase_reg[c] <= ref_n;
                                ttime_reg[c] <= it_reg.now_ms;
                                hits_reg[c]  <= 8'd0;
                            end
                            if (set_let) let_reg[c] <= it_reg.now_ms;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop) it_reg <= item;
        if (state_reg == ST_SUM)
        begin
            neg_reg    <= sum3[25];
            mag_reg    <= 25'(mwtd_pkg::abs26(sum3));
            simple_reg <= (hcnt_reg[c] == 2'd0) ? 24'sd0 :
                          (hcnt_reg[c] == 2'd1) ? hist_reg[c][0] : 24'(half2);
        end
        if (state_reg == ST_MUL) prod_reg <= 49'(mag_reg) * 49'(mwtd_pkg::RECIP3);
    end

`ifndef SYNTHESIS
    a_no_phase3: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg[0] != 2'd3 && phase_reg[1] != 2'd3)
        else $error("phase 3 reached");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full queue");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |=> state_reg == ST_SUM)
        else $error("sample pop did not start work");
    a_exec_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |=> state_reg == ST_EXEC)
        else $error("pipeline sequence broken");
`endif
endmodule

[hdl/mwtd_outq.sv]
// mwtd_outq: two-entry result queue driving the event ports.
// Depends on mwtd_pkg.
module mwtd_outq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   res_push,
    input  mwtd_pkg::mwtd_result_t res,
    output logic                   res_full,
    output logic                   empty,
    input  logic                   pop,
    output logic                   event_compartment,
    output logic [1:0]             event_kind,
    output logic                   medicine_taken
);
    mwtd_pkg::mwtd_result_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       wptr_reg, rptr_reg;
    logic       rd;

    assign res_full          = cnt_reg == 2'd2;
    assign empty             = cnt_reg == 2'd0;
    assign rd                = pop && !empty;
    assign event_compartment = q_reg[rptr_reg].comp;
    assign event_kind        = q_reg[rptr_reg].kind;
    assign medicine_taken    = q_reg[rptr_reg].kind == mwtd_pkg::KIND_TAKE_OK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
        end
        else
        begin
            if (res_push && !rd) cnt_reg <= cnt_reg + 2'd1;
            else if (rd && !res_push) cnt_reg <= cnt_reg - 2'd1;
            if (res_push) wptr_reg <= !wptr_reg;
            if (rd) rptr_reg <= !rptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push) q_reg[wptr_reg] <= res;
    end
endmodule

[dv/mwtd_take_checker.sv]
// mwtd_take_checker: watches the sample, event and register channels of the take detector,
// predicts every event and compares field by field. Depends on mwtd_pkg.
module mwtd_take_checker
    import mwtd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic               compartment,
    input  logic               motion,
    input  logic signed [23:0] weight,
    input  logic [31:0]        now_ms,
    input  logic               empty,
    input  logic               pop,
    input  logic               event_compartment,
    input  logic [1:0]         event_kind,
    input  logic               medicine_taken,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 mismatch_count,
    output int                 events_outstanding
);

    mwtd_result_t expected_events[$];

    // register copy
    logic [22:0] drop_limit, dose_limit, return_limit;
    logic [7:0]  stable_need;
    logic [31:0] wait_win, return_win, quiet_need;
    logic        second_on;

    // per-compartment state
    logic [1:0]  ph[2];
    logic [31:0] edge_t[2], take_t[2], motion_t[2], event_t[2];
    logic        was_high[2], seen[2];
    longint      ref_w[2], base_w[2], prev_w[2];
    longint      hist[2][3];
    int          hist_n[2], hits[2];

    initial mismatch_count = 0;
    initial events_outstanding = 0;

    function automatic longint mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic add_history(input int c, input longint w);
        hist[c][2] = hist[c][1];
        hist[c][1] = hist[c][0];
        hist[c][0] = w;
        if (hist_n[c] < 3) hist_n[c]++;
    endtask

    task automatic advance_compartment(input int c, input logic m, input longint w,
                                       input logic [31:0] t, output logic fire,
                                       output logic [1:0] kind);
        int o;
        logic [31:0] d;
        longint sd;
        o = c ^ 1;
        fire = 1'b0;
        kind = KIND_TAKE_OK;
        if (c == 1 && !second_on) return;
        if (t < BOOT_GUARD_MS_DEF) begin
            add_history(c, w);
            prev_w[c] = w;
            seen[c] = 1'b1;
            if (m) motion_t[c] = t;
            was_high[c] = m;
            return;
        end
        if (!seen[c]) begin
            prev_w[c] = w;
            seen[c] = 1'b1;
        end
        if (m) motion_t[c] = t;
        if (ph[c] == PH_IDLE && m && !was_high[c]) begin
            case (hist_n[c])
                0: ref_w[c] = 0;
                1: ref_w[c] = hist[c][0];
                2: ref_w[c] = (hist[c][0] + hist[c][1]) / 2;
                default: ref_w[c] = (hist[c][0] + hist[c][1] + hist[c][2]) / 3;
            endcase
            add_history(c, w);
            ph[c] = PH_WAIT_TAKE;
            edge_t[c] = t;
        end else begin
            add_history(c, w);
        end
        was_high[c] = m;

        if (ph[c] == PH_WAIT_TAKE) begin
            prev_w[c] = w;
            if (second_on && ph[o] == PH_WAIT_RETURN) begin
                d = edge_t[c] - edge_t[o];
                sd = longint'($signed(d));
                if (mag(sd) < longint'(CROSSTALK_WINDOW_MS_DEF) ||
                    (edge_t[o] != 0 && edge_t[c] > edge_t[o])) begin
                    ph[c] = PH_IDLE;
                    return;
                end
            end
            if (ref_w[c] - w > longint'(drop_limit)) begin
                ph[c] = PH_WAIT_RETURN;
                base_w[c] = ref_w[c];
                take_t[c] = t;
                hits[c] = 0;
                return;
            end
            d = t - edge_t[c];
            if (d > wait_win) begin
                ph[c] = PH_IDLE;
                event_t[c] = t;
                fire = 1'b1;
                kind = KIND_OPEN_NOTAKE;
            end
            return;
        end

        if (ph[c] == PH_WAIT_RETURN) begin
            prev_w[c] = w;
            if (mag(w - base_w[c]) < longint'(return_limit)) begin
                if (hits[c] < 255) hits[c]++;
                if (hits[c] >= int'(stable_need)) begin
                    ph[c] = PH_IDLE;
                    event_t[c] = t;
                    fire = 1'b1;
                    kind = mag(base_w[c] - w) > longint'(dose_limit) ?
                           KIND_TAKE_OK : KIND_TAKE_RETURN;
                    return;
                end
            end else begin
                hits[c] = 0;
            end
            d = t - take_t[c];
            if (d > return_win) begin
                ph[c] = PH_IDLE;
                event_t[c] = t;
                fire = 1'b1;
                kind = KIND_TAKE_OK;
            end
            return;
        end

        // idle: step anomaly once cooled down and motion has been quiet
        if (32'(t - event_t[c]) < IDLE_COOLDOWN_MS_DEF ||
            32'(t - motion_t[c]) < quiet_need) begin
            prev_w[c] = w;
            return;
        end
        sd = w - prev_w[c];
        prev_w[c] = w;
        if (mag(sd) > longint'(drop_limit)) begin
            event_t[c] = t;
            fire = 1'b1;
            kind = KIND_NO_MOTION;
        end
    endtask

    always @(posedge clk) begin
        logic fire;
        logic [1:0] kind;
        mwtd_result_t exp_ev;
        if (!rst_n) begin
            drop_limit = 23'd20000;
            dose_limit = 23'd2000;
            return_limit = 23'd10000;
            stable_need = 8'd3;
            wait_win = 32'd10000;
            return_win = 32'd30000;
            quiet_need = 32'd5000;
            second_on = 1'b1;
            for (int c = 0; c < 2; c++) begin
                ph[c] = PH_IDLE;
                edge_t[c] = '0; take_t[c] = '0; motion_t[c] = '0; event_t[c] = '0;
                was_high[c] = 1'b0; seen[c] = 1'b0;
                ref_w[c] = 0; base_w[c] = 0; prev_w[c] = 0;
                hist[c][0] = 0; hist[c][1] = 0; hist[c][2] = 0;
                hist_n[c] = 0; hits[c] = 0;
            end
            expected_events.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WEIGHT_DELTA: drop_limit = cfg_data[22:0];
                    REG_DOSE:         dose_limit = cfg_data[22:0];
                    REG_RETURN:       return_limit = cfg_data[22:0];
                    REG_STABLE_CNT:   stable_need = cfg_data[7:0];
                    REG_WAIT_WIN:     wait_win = cfg_data;
                    REG_RETURN_WIN:   return_win = cfg_data;
                    REG_NO_MOTION:    quiet_need = cfg_data;
                    REG_SECOND_EN:    second_on = cfg_data[0];
                    default: ;
                endcase
            end
            if (push && !full) begin
                advance_compartment(int'(compartment), motion, longint'(weight), now_ms,
                                    fire, kind);
                if (fire) expected_events.push_back('{comp: compartment, kind: kind});
            end
            if (pop && !empty) begin
                if (expected_events.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected event comp=%0d kind=%0d", $time,
                             event_compartment, event_kind);
                end else begin
                    exp_ev = expected_events.pop_front();
                    if (event_compartment !== exp_ev.comp) begin
                        mismatch_count++;
                        $display("%0t: event_compartment expected %0d got %0d", $time,
                                 exp_ev.comp, event_compartment);
                    end
                    if (event_kind !== exp_ev.kind) begin
                        mismatch_count++;
                        $display("%0t: event_kind expected %0d got %0d", $time,
                                 exp_ev.kind, event_kind);
                    end
                    if (medicine_taken !== (exp_ev.kind == KIND_TAKE_OK)) begin
                        mismatch_count++;
                        $display("%0t: medicine_taken expected %0d got %0d", $time,
                                 exp_ev.kind == KIND_TAKE_OK, medicine_taken);
                    end
                end
            end
        end
        events_outstanding = expected_events.size();
    end

endmodule

[dv/tb_motion_weight_take_detector_top.sv]
// tb_motion_weight_take_detector_top: stimulus, register phases and verdict for the
// take detector. Depends on mwtd_pkg, motion_weight_take_detector_top, mwtd_take_checker.
module tb_motion_weight_take_detector_top;
    import mwtd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic               compartment = 1'b0;
    logic               motion = 1'b0;
    logic signed [23:0] weight = '0;
    logic [31:0]        now_ms = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic               event_compartment;
    logic [1:0]         event_kind;
    logic               medicine_taken;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    int mismatch_count;
    int events_outstanding;

    // idling knobs, in percent
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // long receiver hold-off, requested by the stimulus, counted by the receiver
    bit hold_request = 1'b0;
    int hold_left = 0;

    int cycle_count = 0;
    int items_sent = 0;
    logic [31:0] clock_ms = '0;   // running sample time for well-formed sequences

    motion_weight_take_detector_top dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .compartment(compartment), .motion(motion), .weight(weight), .now_ms(now_ms),
        .empty(empty), .pop(pop),
        .event_compartment(event_compartment), .event_kind(event_kind),
        .medicine_taken(medicine_taken),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    mwtd_take_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .compartment(compartment), .motion(motion), .weight(weight), .now_ms(now_ms),
        .empty(empty), .pop(pop),
        .event_compartment(event_compartment), .event_kind(event_kind),
        .medicine_taken(medicine_taken),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatch_count(mismatch_count), .events_outstanding(events_outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("motion_weight_take_detector_top regression: fail");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off when asked for
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = 700;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // offer one item; returns at the edge where it is taken, then idles at random
    task automatic put(input logic c, input logic m, input longint w, input logic [31:0] t);
        push <= 1'b1;
        compartment <= c;
        motion <= m;
        weight <= w[23:0];
        now_ms <= t;
        @(posedge clk);
        while (full) @(posedge clk);
        items_sent++;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    // sample on the running clock; mostly short spacing, now and then a long jump
    task automatic step(input logic c, input logic m, input longint w);
        if ($urandom_range(9) == 0)
            clock_ms += $urandom_range(45000, 5000);
        else
            clock_ms += $urandom_range(1500, 50);
        put(c, m, w, clock_ms);
    endtask

    // drain: nothing expected, then let any no-event sample still inside finish
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (events_outstanding != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] wd, input logic [31:0] dose,
                             input logic [31:0] ret, input logic [31:0] stable,
                             input logic [31:0] wwin, input logic [31:0] rwin,
                             input logic [31:0] quiet, input logic [31:0] en2);
        wait_idle();
        write_reg(REG_WEIGHT_DELTA, wd);
        write_reg(REG_DOSE, dose);
        write_reg(REG_RETURN, ret);
        write_reg(REG_STABLE_CNT, stable);
        write_reg(REG_WAIT_WIN, wwin);
        write_reg(REG_RETURN_WIN, rwin);
        write_reg(REG_NO_MOTION, quiet);
        write_reg(REG_SECOND_EN, en2);
    endtask

    // one pill-taking sequence: quiet, motion edge, drop, settle back near base
    task automatic dose_cycle(input logic c);
        longint base;
        longint take;
        longint dose;
        base = longint'($urandom_range(2000000)) - 1000000;
        take = longint'($urandom_range(60000));
        dose = longint'($urandom_range(6000));
        repeat ($urandom_range(3)) step(c, 1'b0, base + longint'($urandom_range(1000)) - 500);
        step(c, 1'b1, base);
        // sibling motion close by: crosstalk cancel path
        if ($urandom_range(9) < 3)
            step(~c, 1'b1, longint'($urandom_range(200000)) - 100000);
        repeat ($urandom_range(2, 1)) step(c, 1'($urandom_range(1)), base - take);
        repeat ($urandom_range(6)) step(c, 1'b0,
                                       base - dose + longint'($urandom_range(6000)) - 3000);
        step(c, 1'b0, base - dose);
    endtask

    // idle weight step after motion has been quiet a while
    task automatic quiet_step(input logic c);
        longint w0;
        w0 = longint'($urandom_range(2000000)) - 1000000;
        clock_ms += $urandom_range(12000, 6000);
        put(c, 1'b0, w0, clock_ms);
        step(c, 1'b0, w0 + longint'($urandom_range(200000)) - 100000);
    endtask

    task automatic random_phase(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                dose_cycle(1'($urandom_range(1)));
            else if (pick < 85)
                quiet_step(1'($urandom_range(1)));
            else
                put(1'($urandom_range(1)), 1'($urandom_range(1)),
                    longint'($urandom), $urandom);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, default registers
        put(1'b0, 1'b1, -8388608, 32'd0);           // boot guard, extremes
        put(1'b1, 1'b0, 8388607, 32'd4999);
        put(1'b0, 1'b0, 100000, 32'd5000);
        put(1'b0, 1'b0, 100000, 32'd6000);
        put(1'b0, 1'b1, 100000, 32'd7000);          // arm
        put(1'b0, 1'b1, 50000, 32'd7500);           // drop, but the boot sample keeps the reference low: no take
        put(1'b0, 1'b0, 98000, 32'd8000);           // steady weight while still waiting for a take
        put(1'b0, 1'b0, 98000, 32'd8500);
        put(1'b0, 1'b0, 98000, 32'd9000);
        put(1'b0, 1'b0, 98000, 32'd9500);
        put(1'b0, 1'b1, 98000, 32'd10000);          // motion while still waiting: no new arm
        put(1'b0, 1'b0, 98000, 32'd30000);          // window out: open, no take
        put(1'b0, 1'b0, 98000, 32'd40000);
        put(1'b0, 1'b0, 20000, 32'd41000);          // step without motion
        put(1'b0, 1'b0, 20000, 32'd49000);
        put(1'b0, 1'b1, 20000, 32'd50000);
        put(1'b0, 1'b1, -30000, 32'd50100);         // compartment 0 waits for return
        put(1'b1, 1'b0, 0, 32'd50150);
        put(1'b1, 1'b1, 0, 32'd50200);              // sibling edge within crosstalk window
        put(1'b0, 1'b0, -30000, 32'd90000);         // return window out: take ok
        put(1'b1, 1'b0, 0, 32'hFFFF_FFFF);
        clock_ms = 32'd100000;

        // defaults, no idling
        random_phase(110);

        // low extremes, sender idle
        configure(0, 0, 32'h7FFFFF, 1, 0, 0, 0, 1);
        send_idle_pct = 75;
        random_phase(110);

        // high extremes, second scale off, receiver stalls
        configure(32'h7FFFFF, 32'h7FFFFF, 0, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 0);
        send_idle_pct = 0;
        recv_stall_pct = 75;
        random_phase(100);

        // mid values across the time wrap, both idle, long hold-off
        configure($urandom_range(30000, 5000), $urandom_range(5000, 500),
                  $urandom_range(15000, 3000), $urandom_range(4), $urandom_range(20000, 2000),
                  $urandom_range(40000, 5000), $urandom_range(8000), 1);
        clock_ms = 32'hFFFF_FFFF - 30000;
        send_idle_pct = 6;
        recv_stall_pct = 6;
        hold_request = 1'b1;
        random_phase(140);

        // stable count of zero, short windows, no idling
        configure($urandom_range(40000, 1000), $urandom_range(8000), $urandom_range(20000, 1000),
                  0, $urandom_range(3000), $urandom_range(5000), $urandom_range(3000), 1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(110);

        // fully random registers, mixed idling
        configure($urandom_range(32'h7FFFFF), $urandom_range(32'h7FFFFF),
                  $urandom_range(32'h7FFFFF), $urandom_range(255), $urandom, $urandom,
                  $urandom, $urandom_range(1));
        send_idle_pct = 75;
        recv_stall_pct = 75;
        random_phase(110);

        // wrap-up
        push <= 1'b0;
        @(posedge clk);
        while (events_outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && events_outstanding == 0)
            $display("motion_weight_take_detector_top regression: pass");
        else
            $display("motion_weight_take_detector_top regression: fail");
        $finish;
    end

endmodule
